@@ rtl/sdf_pkg.sv @@
package sdf_pkg;

	localparam int MaxField = 64;
	localparam int CntW = $clog2(MaxField + 1);
	localparam int ValW = 64;
	localparam int NDig = 20;
	localparam int NdW = $clog2(NDig + 1);
	localparam int BcdW = 4 * NDig;

	localparam int FlMinus = 0;
	localparam int FlZero = 1;
	localparam int FlPlus = 2;
	localparam int FlSpace = 3;
	localparam int FlPrec = 4;

	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChPlus = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChZero = 8'h30;

endpackage

@@ rtl/signed_decimal_field_formatter.sv @@
// Formats one signed 64-bit value as a printf %d field, one ASCII character
// per output request, with last set on the final character.
// The input channel (in_valid, in_ready) carries value, flags, width and
// precision. A request is taken only while the block is idle.
// The magnitude is converted to decimal by a shift-and-add-three loop, one
// bit per cycle. Leading zero digits are then shifted out one digit per
// cycle in S_NORM, and the states S_CALC1 and S_CALC2 then size the padding.
// The characters follow at one per cycle through the output register while
// out_ready is high, and the next request is taken in the cycle after the last
// character is loaded.
// A field may be empty (zero value with a given precision of zero, a width of
// zero and no plus or space flag); then no output request is made at all.
// When the receiver holds out_ready low, the output register keeps its
// character and the emission waits; nothing is lost.
// Reset clears the state machine and the output valid flag; the block then
// waits for a request.
module signed_decimal_field_formatter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [sdf_pkg::ValW-1:0]  value,
	input  logic [4:0]                       flags,
	input  logic [6:0]                       width,
	input  logic [5:0]                       precision,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       out_char,
	output logic                             last
);
	import sdf_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CONV = 3'd1;
	localparam logic [2:0] S_NORM = 3'd2;
	localparam logic [2:0] S_CALC1 = 3'd3;
	localparam logic [2:0] S_CALC2 = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0] state_q;
	logic [ValW-1:0] mag_q;
	logic [BcdW-1:0] bcd_q;
	logic [BcdW-1:0] adj;
	logic [$clog2(ValW)-1:0] bit_q;
	logic [NdW-1:0] nd_q;
	logic [4:0] flags_q;
	logic neg_q;
	logic [CntW-1:0] wid_q;
	logic [5:0] prec_q;
	logic [CntW-1:0] plen_q;
	logic [CntW-1:0] lead_q;
	logic sign_q;
	logic [CntW-1:0] zero_q;
	logic [NdW-1:0] dig_q;
	logic [CntW-1:0] len_q;
	logic out_valid_q;
	logic [7:0] out_char_q;
	logic last_q;

	logic [3:0] top_dig;
	logic [CntW-1:0] prec_eff;
	logic [CntW-1:0] nd_ext;
	logic [CntW-1:0] total;
	logic [CntW-1:0] wpad;
	logic [CntW-1:0] len;
	logic has_sign;
	logic zpad;
	logic [7:0] sign_ch;
	logic [7:0] next_ch;

	assign top_dig = bcd_q[BcdW-1 -: 4];
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign last = last_q;

	always_comb begin
		for (int i = 0; i < NDig; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	always_comb begin
		if (!flags_q[FlPrec])
			prec_eff = '0;
		else if (CntW'(prec_q) > CntW'(MaxField - 1))
			prec_eff = CntW'(MaxField - 1);
		else
			prec_eff = CntW'(prec_q);
		nd_ext = CntW'(nd_q);
		has_sign = neg_q | flags_q[FlPlus] | flags_q[FlSpace];
		zpad = flags_q[FlZero] & ~flags_q[FlPrec] & ~flags_q[FlMinus];
		total = CntW'(has_sign) + plen_q + nd_ext;
		wpad = (wid_q > total) ? wid_q - total : '0;
		len = (wid_q > total) ? wid_q : total;
		if (neg_q)
			sign_ch = ChMinus;
		else if (flags_q[FlPlus])
			sign_ch = ChPlus;
		else
			sign_ch = ChSpace;
		if (lead_q != '0)
			next_ch = ChSpace;
		else if (sign_q)
			next_ch = sign_ch;
		else if (zero_q != '0)
			next_ch = ChZero;
		else if (dig_q != '0)
			next_ch = ChZero | {4'b0000, top_dig};
		else
			next_ch = ChSpace;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_CONV;
				end
				S_CONV: begin
					if (bit_q == '1)
						state_q <= S_NORM;
				end
				S_NORM: begin
					if (!(top_dig == 4'd0 && nd_q > NdW'(1)))
						state_q <= S_CALC1;
				end
				S_CALC1: begin
					state_q <= S_CALC2;
				end
				S_CALC2: begin
					state_q <= (len != '0) ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if ((!out_valid_q || out_ready) && len_q == CntW'(1))
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					neg_q <= value[ValW-1];
					mag_q <= value[ValW-1] ? ValW'(~value + 1'b1) : ValW'(value);
					flags_q <= flags;
					wid_q <= (width > 7'(MaxField)) ? CntW'(MaxField) : CntW'(width);
					prec_q <= precision;
					bcd_q <= '0;
					bit_q <= '0;
				end
			end
			S_CONV: begin
				bcd_q <= {adj[BcdW-2:0], mag_q[ValW-1]};
				mag_q <= {mag_q[ValW-2:0], 1'b0};
				bit_q <= bit_q + 1'b1;
				nd_q <= NdW'(NDig);
			end
			S_NORM: begin
				if (top_dig == 4'd0 && nd_q > NdW'(1)) begin
					bcd_q <= {bcd_q[BcdW-5:0], 4'd0};
					nd_q <= nd_q - 1'b1;
				end else if (top_dig == 4'd0 && flags_q[FlPrec] && prec_q == 6'd0) begin
					nd_q <= '0;
				end
			end
			S_CALC1: begin
				plen_q <= (prec_eff > nd_ext) ? prec_eff - nd_ext : '0;
			end
			S_CALC2: begin
				lead_q <= (!flags_q[FlMinus] && !zpad) ? wpad : '0;
				sign_q <= has_sign;
				zero_q <= plen_q + (zpad ? wpad : '0);
				dig_q <= nd_q;
				len_q <= len;
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_char_q <= next_ch;
					last_q <= (len_q == CntW'(1));
					len_q <= len_q - 1'b1;
					if (lead_q != '0)
						lead_q <= lead_q - 1'b1;
					else if (sign_q)
						sign_q <= 1'b0;
					else if (zero_q != '0)
						zero_q <= zero_q - 1'b1;
					else if (dig_q != '0) begin
						dig_q <= dig_q - 1'b1;
						bcd_q <= {bcd_q[BcdW-5:0], 4'd0};
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/sdf_checker.sv @@
module sdf_assert (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic signed [sdf_pkg::ValW-1:0]  value,
	input logic [4:0]                       flags,
	input logic [6:0]                       width,
	input logic [5:0]                       precision,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [7:0]                       out_char,
	input logic                             last
);
	import sdf_pkg::*;

	// A stalled output character holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last))
		else $error("output character changed while stalled");

	// The block is busy after it takes a request.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new request taken right after the previous one");

	// No character can appear in the cycle after a request is taken.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("character emitted before conversion finished");

	// While a field is still incomplete, no new request is taken.
	a_field_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("request accepted in the middle of a field");

endmodule

bind signed_decimal_field_formatter sdf_assert u_sdf_assert (.*);
